/* src/hash_table_put_get_remove_assert.svh */
// Assertion macros for the hash table block.
// Used by the top level only; no other dependencies.
`ifndef HASH_TABLE_PUT_GET_REMOVE_ASSERT_SVH
`define HASH_TABLE_PUT_GET_REMOVE_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent and consequent in the same cycle
`define HTPGR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash table assertion failed");
// consequent in the cycle after the antecedent
`define HTPGR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash table assertion failed");
`else
`define HTPGR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define HTPGR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* src/htpgr_pkg.sv */
// Shared types and constants of the hash table block.
// No dependencies.
package htpgr_pkg;

  localparam int DATA_W = 32;

  // action codes
  localparam logic [1:0] ACT_PUT    = 2'd0;
  localparam logic [1:0] ACT_GET    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  // result of one request, from the way logic to the output registers
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] value;
    logic              full;
  } result_t;

endpackage

/* src/htpgr_hash.sv */
// Bucket index unit: key, read as unsigned, modulo the bucket count.
// Depends on htpgr_pkg.
module htpgr_hash #(
  parameter int BUCKETS = 1024,
  parameter int IDX_W   = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [htpgr_pkg::DATA_W-1:0] key,
  output logic                       done,
  output logic [IDX_W-1:0]           bucket
);
  import htpgr_pkg::*;

  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  if (POW2) begin : g_mask
    // power of two: the bucket is the low key bits, ready at once
    assign done   = start;
    assign bucket = IDX_W'(key & DATA_W'(BUCKETS - 1));
  end else begin : g_recip
    // remainder by reciprocal multiplication: floor(key * RECIP / 2^(DATA_W+L))
    // is the exact quotient for every 32-bit key; only its low IDX_W bits matter
    localparam int L = $clog2(BUCKETS);
    localparam logic [63:0] RECIP =
      ((64'd1 << (DATA_W + L)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [16:0] RECIP_LO = RECIP[16:0];
    localparam logic [15:0] RECIP_HI = RECIP[32:17];
    localparam logic [IDX_W-1:0] B_LO = IDX_W'(BUCKETS);

    logic               ph1;
    logic               ph2;
    logic [DATA_W+16:0] p_lo;
    logic [DATA_W+15:0] p_hi;
    logic [DATA_W+32:0] prod;
    logic [IDX_W-1:0]   key_lo;
    logic [IDX_W-1:0]   quo_lo;

    // full product from the two registered partial products
    assign prod = {p_hi, 17'd0} + (DATA_W+33)'(p_lo);

    // remainder fits in IDX_W bits, so the low bits of key - q*B suffice
    assign done   = ph2;
    assign bucket = key_lo - quo_lo * B_LO;

    always_ff @(posedge clk) begin
      if (rst) begin
        ph1 <= 1'b0;
        ph2 <= 1'b0;
      end else begin
        ph1 <= start;
        ph2 <= ph1;
      end
      if (start) begin
        p_lo   <= (DATA_W+17)'(key) * (DATA_W+17)'(RECIP_LO);
        p_hi   <= (DATA_W+16)'(key) * (DATA_W+16)'(RECIP_HI);
        key_lo <= key[IDX_W-1:0];
      end
      if (ph1) begin
        quo_lo <= prod[DATA_W + L +: IDX_W];
      end
    end
  end

endmodule

/* src/htpgr_ram.sv */
// Bucket row memory: one write port, one read port, registered read data.
// No dependencies.
module htpgr_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int WIDTH = 260
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/htpgr_ways.sv */
// Way logic: compares the ways of one bucket row and builds the new row.
// Depends on htpgr_pkg. Row layout: values, keys, valid bits (LSB side).
module htpgr_ways #(
  parameter int WAYS  = 4,
  parameter int ROW_W = 260
) (
  input  logic [1:0]                   action,
  input  logic [htpgr_pkg::DATA_W-1:0] key,
  input  logic [htpgr_pkg::DATA_W-1:0] value,
  input  logic [ROW_W-1:0]             row,
  output logic [ROW_W-1:0]             row_next,
  output htpgr_pkg::result_t           res
);
  import htpgr_pkg::*;

  localparam int KEY_LO = WAYS;
  localparam int VAL_LO = WAYS + WAYS * DATA_W;

  logic [WAYS-1:0]   match;
  logic [WAYS-1:0]   match_sel;
  logic [WAYS-1:0]   free_sel;
  logic              found;
  logic              have_free;
  logic [DATA_W-1:0] hit_value;

  // parallel key compare, then first match and first free way
  always_comb begin
    found     = 1'b0;
    have_free = 1'b0;
    match_sel = '0;
    free_sel  = '0;
    hit_value = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row[w] && (row[KEY_LO + w*DATA_W +: DATA_W] == key);
      if (match[w] && !found) begin
        found        = 1'b1;
        match_sel[w] = 1'b1;
      end
      if (!row[w] && !have_free) begin
        have_free   = 1'b1;
        free_sel[w] = 1'b1;
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (match_sel[w]) begin
        hit_value = hit_value | row[VAL_LO + w*DATA_W +: DATA_W];
      end
    end
  end

  // new row contents
  always_comb begin
    row_next = row;
    for (int w = 0; w < WAYS; w++) begin
      if (action == ACT_PUT) begin
        if (match_sel[w]) begin
          row_next[VAL_LO + w*DATA_W +: DATA_W] = value;
        end else if (!found && free_sel[w]) begin
          row_next[w]                           = 1'b1;
          row_next[KEY_LO + w*DATA_W +: DATA_W] = key;
          row_next[VAL_LO + w*DATA_W +: DATA_W] = value;
        end
      end else if (action == ACT_REMOVE && match_sel[w]) begin
        row_next[w] = 1'b0;
      end
    end
  end

  // result fields
  always_comb begin
    res = '0;
    case (action)
      ACT_PUT: begin
        res.hit  = found;
        res.full = !found && !have_free;
      end
      ACT_GET: begin
        res.hit   = found;
        res.value = found ? hit_value : MISS_VALUE;
      end
      ACT_REMOVE: begin
        res.hit = found;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

/* src/hash_table_put_get_remove.sv */
// Hash table of 32-bit keys and values, BUCKETS buckets of WAYS ways, one
// row per bucket in a single-port-read synchronous memory. After reset the
// block clears every row, one row per cycle, with busy high. An item is
// taken when start is high and busy low; its bucket row is read, compared
// across all ways, and written back in the following cycle. With a
// power-of-two bucket count the row is read as the item is taken; otherwise
// the bucket index first comes from a reciprocal multiplication in two
// registered steps. The result appears on hit, read_value and bucket_full,
// with done high for one cycle, the cycle after the write-back;
// it cannot be held off and must be taken then.
// Depends on htpgr_pkg, htpgr_hash, htpgr_ram, htpgr_ways.
`include "hash_table_put_get_remove_assert.svh"

module hash_table_put_get_remove #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        action,
  input  logic signed [htpgr_pkg::DATA_W-1:0] lookup_key,
  input  logic signed [htpgr_pkg::DATA_W-1:0] store_value,
  output logic                              done,
  output logic                              hit,
  output logic signed [htpgr_pkg::DATA_W-1:0] read_value,
  output logic                              bucket_full
);
  import htpgr_pkg::*;

  localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int ROW_W = WAYS * (1 + 2 * DATA_W);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_EXEC
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  clr_idx;
  logic [1:0]        act_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] val_q;
  logic [IDX_W-1:0]  bucket_q;

  logic              accept;
  logic              hash_done;
  logic [IDX_W-1:0]  hash_bucket;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;
  logic [ROW_W-1:0]  mem_rdata;
  logic [ROW_W-1:0]  row_next;
  result_t           res;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // bucket index
  htpgr_hash #(
    .BUCKETS (BUCKETS),
    .IDX_W   (IDX_W)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .key    (lookup_key),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  // write port: clearing sweep, or write-back of the updated row
  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_EXEC);
    mem_waddr = (state == S_CLEAR) ? clr_idx : bucket_q;
    mem_wdata = (state == S_CLEAR) ? '0 : row_next;
  end

  htpgr_ram #(
    .DEPTH (BUCKETS),
    .AW    (IDX_W),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (hash_done),
    .raddr (hash_bucket),
    .rdata (mem_rdata)
  );

  htpgr_ways #(
    .WAYS  (WAYS),
    .ROW_W (ROW_W)
  ) u_ways (
    .action   (act_q),
    .key      (key_q),
    .value    (val_q),
    .row      (mem_rdata),
    .row_next (row_next),
    .res      (res)
  );

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= (state == S_EXEC);
      if (hash_done) begin
        bucket_q <= hash_bucket;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            act_q <= action;
            key_q <= lookup_key;
            val_q <= store_value;
            state <= hash_done ? S_EXEC : S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          hit         <= res.hit;
          read_value  <= res.value;
          bucket_full <= res.full;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `HTPGR_ASSERT_NEXT(a_exec_gives_result, clk, rst, state == S_EXEC, done)
  `HTPGR_ASSERT_NEXT(a_accept_goes_busy, clk, rst, accept, busy)
  `HTPGR_ASSERT_SAME(a_full_never_hit, clk, rst, done, !(hit && bucket_full))

endmodule
